// File: hdl/geometry_collision_test_core_defines.svh
// Assertion macros used by the checker of the collision test core.
`ifndef GEOMETRY_COLLISION_TEST_CORE_DEFINES_SVH
`define GEOMETRY_COLLISION_TEST_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GCT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gct assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GCT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gct assertion failed");

`endif

// File: hdl/gct_pkg.sv
package gct_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int OP_WIDTH        = 2;
    localparam int M_TDATA_WIDTH   = 8;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_RECT_RECT  = 2'd0,
        OP_RECT_POINT = 2'd1,
        OP_RECT_SEG   = 2'd2,
        OP_SEG_SEG    = 2'd3
    } op_t;

    // Sign of a value held as two flags; both low means zero.
    typedef struct packed {
        logic pos;
        logic neg;
    } sign_t;

    function automatic sign_t sgn_mul(input sign_t a, input sign_t b);
        sign_t r;
        r.pos = (a.pos & b.pos) | (a.neg & b.neg);
        r.neg = (a.pos & b.neg) | (a.neg & b.pos);
        return r;
    endfunction

    // True when both signs are nonzero and equal, i.e. their product is positive.
    function automatic logic same_side(input sign_t a, input sign_t b);
        return (a.pos & b.pos) | (a.neg & b.neg);
    endfunction

endpackage

// File: hdl/gct_cross_unit.sv
module gct_cross_unit #(
    parameter int DIFF_WIDTH = gct_pkg::COORD_WIDTH_DEF + 1
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [DIFF_WIDTH-1:0]   ex,
    input  logic signed [DIFF_WIDTH-1:0]   ey,
    input  logic signed [DIFF_WIDTH-1:0]   fx,
    input  logic signed [DIFF_WIDTH-1:0]   fy,
    output logic signed [2*DIFF_WIDTH-1:0] p_out,
    output logic signed [2*DIFF_WIDTH-1:0] q_out
);

    logic signed [2*DIFF_WIDTH-1:0] p_reg, p_next;
    logic signed [2*DIFF_WIDTH-1:0] q_reg, q_next;

    // The two terms of the cross product, kept exact.
    assign p_next = ex * ey;
    assign q_next = fx * fy;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
            q_reg <= q_next;
        end
    end

    assign p_out = p_reg;
    assign q_out = q_reg;

endmodule

// File: hdl/geometry_collision_test_core.sv
// An input transfer passes through three register stages (operand differences,
// exact products, cross-product sign and combine) before its result shows on m_.
// Throughput: one shape pair per cycle while the m_ side does not stall.
// A stall on the m_ side holds every stage that has no room to move.
// Reset (aresetn low, synchronous) clears all stage valid bits; data is not cleared.
module geometry_collision_test_core #(
    parameter int COORD_WIDTH = gct_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // operation
    input  logic [gct_pkg::OP_WIDTH-1:0]          s_tuser,
    // first_x1, first_y1, first_x2, first_y2, second_x1, second_y1, second_x2, second_y2
    input  logic [8*COORD_WIDTH-1:0]              s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // hit, then zero padding
    output logic [gct_pkg::M_TDATA_WIDTH-1:0]     m_tdata
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;
    localparam int NU = 4;

    typedef logic signed [W-1:0]  coord_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [CW-1:0] cross_t;

    // Rectangle-side results that need no multiply.
    typedef struct packed {
        logic rr_hit;
        logic pt_in;
        logic top_miss;
        logic left_miss;
        logic right_miss;
        logic bot_miss;
    } flags_t;

    function automatic logic in_rng(input coord_t a, input coord_t b, input coord_t c);
        if (b <= c) begin
            return (b <= a) && (a <= c);
        end
        return (c <= a) && (a <= b);
    endfunction

    function automatic gct_pkg::sign_t cmp(input coord_t x, input coord_t y);
        gct_pkg::sign_t r;
        r.pos = x > y;
        r.neg = x < y;
        return r;
    endfunction

    function automatic diff_t dif(input coord_t a, input coord_t b);
        return $signed({a[W-1], a}) - $signed({b[W-1], b});
    endfunction

    // Handshake chain
    logic vld_a_reg, vld_a_next;
    logic vld_b_reg, vld_b_next;
    logic vld_c_reg, vld_c_next;
    logic rdy_a, rdy_b, rdy_c;
    logic en_a, en_b, en_c;

    assign rdy_c = !vld_c_reg || m_tready;
    assign rdy_b = !vld_b_reg || rdy_c;
    assign rdy_a = !vld_a_reg || rdy_b;
    assign en_a  = rdy_a && s_tvalid;
    assign en_b  = rdy_b && vld_a_reg;
    assign en_c  = rdy_c && vld_b_reg;

    always_comb begin
        vld_a_next = vld_a_reg;
        vld_b_next = vld_b_reg;
        vld_c_next = vld_c_reg;
        if (rdy_a) begin
            vld_a_next = s_tvalid;
        end
        if (rdy_b) begin
            vld_b_next = vld_a_reg;
        end
        if (rdy_c) begin
            vld_c_next = vld_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end else begin
            vld_a_reg <= vld_a_next;
            vld_b_reg <= vld_b_next;
            vld_c_reg <= vld_c_next;
        end
    end

    // Stage A: unpack, compares and operand differences
    gct_pkg::op_t op_in;
    coord_t       l, t, r, b, sx1, sy1, sx2, sy2;
    coord_t       ax [NU];
    coord_t       ay [NU];
    coord_t       bx [NU];
    coord_t       by [NU];
    coord_t       mx [NU];
    coord_t       my [NU];
    diff_t        ex_next [NU];
    diff_t        ey_next [NU];
    diff_t        fx_next [NU];
    diff_t        fy_next [NU];
    flags_t       flags_a_next;
    gct_pkg::sign_t s_rl, s_bt;

    assign op_in = gct_pkg::op_t'(s_tuser);
    assign l   = s_tdata[0*W +: W];
    assign t   = s_tdata[1*W +: W];
    assign r   = s_tdata[2*W +: W];
    assign b   = s_tdata[3*W +: W];
    assign sx1 = s_tdata[4*W +: W];
    assign sy1 = s_tdata[5*W +: W];
    assign sx2 = s_tdata[6*W +: W];
    assign sy2 = s_tdata[7*W +: W];

    assign s_rl = cmp(r, l);
    assign s_bt = cmp(b, t);

    // Units 0 and 1 put the corners (l,t) and (r,b) against the second segment.
    // Units 2 and 3 put corners (r,t) and (l,b) against it for rect-segment, and
    // for segment-segment put the second segment's ends against the first.
    always_comb begin
        for (int k = 0; k < NU; k++) begin
            ax[k] = sx1;
            ay[k] = sy1;
            bx[k] = sx2;
            by[k] = sy2;
        end
        mx[0] = l;
        my[0] = t;
        mx[1] = r;
        my[1] = b;
        mx[2] = r;
        my[2] = t;
        mx[3] = l;
        my[3] = b;
        if (op_in == gct_pkg::OP_SEG_SEG) begin
            for (int k = 2; k < NU; k++) begin
                ax[k] = l;
                ay[k] = t;
                bx[k] = r;
                by[k] = b;
            end
            mx[2] = sx1;
            my[2] = sy1;
            mx[3] = sx2;
            my[3] = sy2;
        end
        for (int k = 0; k < NU; k++) begin
            ex_next[k] = dif(bx[k], ax[k]);
            ey_next[k] = dif(my[k], ay[k]);
            fx_next[k] = dif(mx[k], ax[k]);
            fy_next[k] = dif(by[k], ay[k]);
        end
    end

    // Against an axis-aligned edge the cross product reduces to a product of
    // signs. The sign flip on the vertical edges cancels in a same-side test.
    always_comb begin
        flags_a_next.rr_hit =
            (in_rng(l, sx1, sx2) || in_rng(r, sx1, sx2) || in_rng(sx1, l, r)) &&
            (in_rng(t, sy1, sy2) || in_rng(b, sy1, sy2) || in_rng(sy1, t, b));
        flags_a_next.pt_in = in_rng(sx1, l, r) && in_rng(sy1, t, b);
        flags_a_next.top_miss = gct_pkg::same_side(
            gct_pkg::sgn_mul(s_rl, cmp(sy1, t)), gct_pkg::sgn_mul(s_rl, cmp(sy2, t)));
        flags_a_next.bot_miss = gct_pkg::same_side(
            gct_pkg::sgn_mul(s_rl, cmp(sy1, b)), gct_pkg::sgn_mul(s_rl, cmp(sy2, b)));
        flags_a_next.left_miss = gct_pkg::same_side(
            gct_pkg::sgn_mul(cmp(sx1, l), s_bt), gct_pkg::sgn_mul(cmp(sx2, l), s_bt));
        flags_a_next.right_miss = gct_pkg::same_side(
            gct_pkg::sgn_mul(cmp(sx1, r), s_bt), gct_pkg::sgn_mul(cmp(sx2, r), s_bt));
    end

    gct_pkg::op_t op_a_reg;
    flags_t       flags_a_reg;
    diff_t        ex_a_reg [NU];
    diff_t        ey_a_reg [NU];
    diff_t        fx_a_reg [NU];
    diff_t        fy_a_reg [NU];

    always_ff @(posedge aclk) begin
        if (en_a) begin
            op_a_reg    <= op_in;
            flags_a_reg <= flags_a_next;
            for (int k = 0; k < NU; k++) begin
                ex_a_reg[k] <= ex_next[k];
                ey_a_reg[k] <= ey_next[k];
                fx_a_reg[k] <= fx_next[k];
                fy_a_reg[k] <= fy_next[k];
            end
        end
    end

    // Stage B: exact products
    prod_t        p_b [NU];
    prod_t        q_b [NU];
    gct_pkg::op_t op_b_reg;
    flags_t       flags_b_reg;

    for (genvar g = 0; g < NU; g++) begin : g_unit
        gct_cross_unit #(
            .DIFF_WIDTH (DW)
        ) u_cross (
            .aclk  (aclk),
            .en    (en_b),
            .ex    (ex_a_reg[g]),
            .ey    (ey_a_reg[g]),
            .fx    (fx_a_reg[g]),
            .fy    (fy_a_reg[g]),
            .p_out (p_b[g]),
            .q_out (q_b[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            op_b_reg    <= op_a_reg;
            flags_b_reg <= flags_a_reg;
        end
    end

    // Stage C: cross-product signs and the final decision
    cross_t         xprod [NU];
    gct_pkg::sign_t side  [NU];
    logic           meet_top, meet_left, meet_right, meet_bot;
    logic           hit_next, hit_reg;

    always_comb begin
        for (int k = 0; k < NU; k++) begin
            xprod[k]    = $signed({p_b[k][PW-1], p_b[k]}) - $signed({q_b[k][PW-1], q_b[k]});
            side[k].neg = xprod[k][CW-1];
            side[k].pos = !xprod[k][CW-1] && (xprod[k] != '0);
        end
        // Corner order: 0 is (l,t), 1 is (r,b), 2 is (r,t), 3 is (l,b).
        meet_top   = !(gct_pkg::same_side(side[0], side[2]) || flags_b_reg.top_miss);
        meet_left  = !(gct_pkg::same_side(side[0], side[3]) || flags_b_reg.left_miss);
        meet_right = !(gct_pkg::same_side(side[2], side[1]) || flags_b_reg.right_miss);
        meet_bot   = !(gct_pkg::same_side(side[3], side[1]) || flags_b_reg.bot_miss);
        case (op_b_reg)
            gct_pkg::OP_RECT_RECT: begin
                hit_next = flags_b_reg.rr_hit;
            end
            gct_pkg::OP_RECT_POINT: begin
                hit_next = flags_b_reg.pt_in;
            end
            gct_pkg::OP_RECT_SEG: begin
                hit_next = flags_b_reg.pt_in || meet_top || meet_left ||
                           meet_right || meet_bot;
            end
            gct_pkg::OP_SEG_SEG: begin
                hit_next = !(gct_pkg::same_side(side[0], side[1]) ||
                             gct_pkg::same_side(side[2], side[3]));
            end
            default: begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en_c) begin
            hit_reg <= hit_next;
        end
    end

    assign s_tready = rdy_a;
    assign m_tvalid = vld_c_reg;
    assign m_tdata  = {{(gct_pkg::M_TDATA_WIDTH-1){1'b0}}, hit_reg};

endmodule

// File: hdl/gct_checker.sv
`include "geometry_collision_test_core_defines.svh"

module gct_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [gct_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

    // A result that is not taken stays, unchanged.
    `GCT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The input side only stalls when the whole pipeline is full and the output is held.
    `GCT_ASSERT_NOW(a_stall_chain, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

    // No result is shown in the first cycle after reset.
    `GCT_ASSERT_NOW(a_reset_empty, aclk, aresetn, $past(!aresetn), !m_tvalid)

    // Only the hit bit of the output data may be set.
    `GCT_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[gct_pkg::M_TDATA_WIDTH-1:1] == '0)

endmodule

bind geometry_collision_test_core gct_checker u_gct_checker (.*);
